// File: hw/rtl/opc_pkg.sv
// Shared types and constants for the object-to-camera projection core.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
package opc_pkg;

	localparam int COORD_W   = 32;
	localparam int ROT_W     = 16;
	localparam int ROT_COL_W = 3 * ROT_W;
	localparam int F_W       = 24;
	localparam int OUT_FRAC  = 8;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + ROT_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int MAG_W     = ACC_W - 1;
	localparam int PP_SPLIT  = (MAG_W + 1) / 2;
	localparam int PP_W      = (MAG_W - PP_SPLIT) + F_W;
	localparam int NUM_W     = MAG_W + F_W + OUT_FRAC;
	localparam int QW        = 32;
	localparam int HEAD_W    = NUM_W - QW;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_ROT_COL_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_COL_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_COL_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd6;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ZERO_DEPTH = 2'd1;
	localparam logic [1:0] ST_SAT        = 2'd2;

	typedef struct packed {
		logic        [31:0] point_id;
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
		logic signed [31:0] obj_z;
	} point_t;

	typedef struct packed {
		logic        [31:0] point_out_id;
		logic signed [31:0] image_x;
		logic signed [31:0] image_y;
		logic        [1:0]  status;
	} image_t;

	typedef struct packed {
		logic [2:0][ROT_COL_W-1:0]  rot_col;
		logic [2:0][COORD_W-1:0]    cam;
		logic [F_W-1:0]             focal;
	} cfg_t;

	// Per-item flags that ride alongside the arithmetic.
	typedef struct packed {
		logic [31:0] id;
		logic        neg_x;
		logic        neg_y;
		logic        zero_den;
	} side_t;

endpackage

// File: hw/rtl/object_to_camera_projection_core.sv
// Top level of the collinearity projection core: configuration registers, pipeline and output stage.
// Instantiates opc_front, opc_scale and opc_div; depends on opc_pkg.
`timescale 1ns / 1ps
// Projects one object point per transfer into image coordinates: subtract the camera centre,
// rotate by the configured matrix, divide the first two rotated components by the depth and
// scale by minus the focal length, with 8 fraction bits, truncation toward zero and saturation.
// A new point is taken every cycle unless point_stall is high; each result passes through
// 4 front stages, 3 scaling stages, 32 divider stages - one quotient bit each - and the output
// register. The whole pipeline advances together: when the output holds a result that the sink
// stalls, point_stall rises and every stage holds. A zero depth gives status 1 and zero
// coordinates; saturation gives status 2. Write configuration only while the pipeline is empty.
module object_to_camera_projection_core import opc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  point_t               point,
	output logic                 image_valid,
	input  logic                 image_stall,
	output image_t               image,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              en;
	logic              valid_s4, valid_s7, valid_div;
	side_t             side_s4, side_s7, side_div;
	logic [MAG_W-1:0]  mag_s4 [3];
	logic [MAG_W-1:0]  den_s7;
	logic [HEAD_W-1:0] head_s7 [2];
	logic [QW-1:0]     tail_s7 [2];
	logic [1:0]        ovf_s7, ovf_div;
	logic [QW-1:0]     quo_div [2];
	logic              out_valid_q;
	image_t            out_q;
	logic [31:0]       coord [2];
	logic [1:0]        sat;

	// Advance whenever the output register is free or being emptied.
	assign en          = !out_valid_q || !image_stall;
	assign point_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_col[0] <= 48'd16384;
			cfg_q.rot_col[1] <= 48'd1073741824;
			cfg_q.rot_col[2] <= 48'd70368744177664;
			cfg_q.cam        <= '0;
			cfg_q.focal      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_COL_0: cfg_q.rot_col[0] <= cfg_data;
				REG_ROT_COL_1: cfg_q.rot_col[1] <= cfg_data;
				REG_ROT_COL_2: cfg_q.rot_col[2] <= cfg_data;
				REG_CAM_X:     cfg_q.cam[0]     <= cfg_data[COORD_W-1:0];
				REG_CAM_Y:     cfg_q.cam[1]     <= cfg_data[COORD_W-1:0];
				REG_CAM_Z:     cfg_q.cam[2]     <= cfg_data[COORD_W-1:0];
				REG_FOCAL:     cfg_q.focal      <= cfg_data[F_W-1:0];
				default: ;
			endcase
		end
	end

	opc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (point_valid),
		.in_item  (point),
		.cfg      (cfg_q),
		.valid_s4 (valid_s4),
		.side_s4  (side_s4),
		.mag_s4   (mag_s4)
	);

	opc_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.in_side  (side_s4),
		.in_mag   (mag_s4),
		.focal    (cfg_q.focal),
		.valid_s7 (valid_s7),
		.side_s7  (side_s7),
		.den_s7   (den_s7),
		.head_s7  (head_s7),
		.tail_s7  (tail_s7),
		.ovf_s7   (ovf_s7)
	);

	opc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.in_side   (side_s7),
		.in_den    (den_s7),
		.in_head   (head_s7),
		.in_tail   (tail_s7),
		.in_ovf    (ovf_s7),
		.out_valid (valid_div),
		.out_side  (side_div),
		.out_ovf   (ovf_div),
		.out_quo   (quo_div)
	);

	// Apply sign and clamp each magnitude quotient to the 32-bit signed range.
	always_comb begin
		logic neg [2];
		neg[0] = side_div.neg_x;
		neg[1] = side_div.neg_y;
		for (int l = 0; l < 2; l++) begin
			if (neg[l]) begin
				if (ovf_div[l] || quo_div[l] > 32'h8000_0000) begin
					coord[l] = 32'h8000_0000;
					sat[l]   = 1'b1;
				end else begin
					coord[l] = -quo_div[l];
					sat[l]   = 1'b0;
				end
			end else begin
				if (ovf_div[l] || quo_div[l][QW-1]) begin
					coord[l] = 32'h7FFF_FFFF;
					sat[l]   = 1'b1;
				end else begin
					coord[l] = quo_div[l];
					sat[l]   = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_div;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.point_out_id <= side_div.id;
			if (side_div.zero_den) begin
				out_q.image_x <= '0;
				out_q.image_y <= '0;
				out_q.status  <= ST_ZERO_DEPTH;
			end else begin
				out_q.image_x <= coord[0];
				out_q.image_y <= coord[1];
				out_q.status  <= (sat != 2'b00) ? ST_SAT : ST_OK;
			end
		end
	end

	assign image_valid = out_valid_q;
	assign image       = out_q;

	a_stall_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && image_stall) |-> point_stall)
		else $error("input not stalled while output held");

	a_zero_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(image_valid && image.status == ST_ZERO_DEPTH) |-> (image.image_x == 0 && image.image_y == 0))
		else $error("zero depth result with nonzero coordinates");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(image_valid && image.status == ST_SAT) |->
		(image.image_x == 32'sh7FFF_FFFF || image.image_x == 32'sh8000_0000 ||
		 image.image_y == 32'sh7FFF_FFFF || image.image_y == 32'sh8000_0000))
		else $error("saturated status without a clamped coordinate");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		image_valid |-> (image.status == ST_OK || image.status == ST_ZERO_DEPTH ||
		                 image.status == ST_SAT))
		else $error("unused status code");

endmodule

// File: hw/rtl/opc_front.sv
// Front end: camera offset, rotation products, dot-product sums, sign/magnitude.
// Four pipeline stages; depends on opc_pkg.
`timescale 1ns / 1ps
module opc_front import opc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  point_t           in_item,
	input  cfg_t             cfg,
	output logic             valid_s4,
	output side_t            side_s4,
	output logic [MAG_W-1:0] mag_s4 [3]
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic [31:0]              id_s1, id_s2, id_s3;
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [3][3];
	logic signed [ACC_W-1:0]  acc_s3 [3];
	logic signed [DIFF_W-1:0] obj [3];
	logic signed [ACC_W-1:0]  neg_acc [3];

	assign obj[0] = DIFF_W'(in_item.obj_x);
	assign obj[1] = DIFF_W'(in_item.obj_y);
	assign obj[2] = DIFF_W'(in_item.obj_z);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			neg_acc[c] = -acc_s3[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s1 <= in_item.point_id;
			for (int r = 0; r < 3; r++) begin
				d_s1[r] <= obj[r] - DIFF_W'($signed(cfg.cam[r]));
			end
			id_s2 <= id_s1;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					p_s2[c][r] <= $signed(cfg.rot_col[c][ROT_W*r +: ROT_W]) * d_s1[r];
				end
			end
			id_s3 <= id_s2;
			for (int c = 0; c < 3; c++) begin
				acc_s3[c] <= ACC_W'(p_s2[c][0]) + ACC_W'(p_s2[c][1]) + ACC_W'(p_s2[c][2]);
			end
			// result sign is flipped by the minus on the focal length
			side_s4.id       <= id_s3;
			side_s4.neg_x    <= acc_s3[0][ACC_W-1] == acc_s3[2][ACC_W-1];
			side_s4.neg_y    <= acc_s3[1][ACC_W-1] == acc_s3[2][ACC_W-1];
			side_s4.zero_den <= acc_s3[2] == '0;
			for (int c = 0; c < 3; c++) begin
				mag_s4[c] <= acc_s3[c][ACC_W-1] ? neg_acc[c][MAG_W-1:0] : acc_s3[c][MAG_W-1:0];
			end
		end
	end

endmodule

// File: hw/rtl/opc_scale.sv
// Focal scaling of both numerators and divider set-up (overflow check, head of dividend).
// Three pipeline stages; depends on opc_pkg.
`timescale 1ns / 1ps
module opc_scale import opc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  side_t             in_side,
	input  logic [MAG_W-1:0]  in_mag [3],
	input  logic [F_W-1:0]    focal,
	output logic              valid_s7,
	output side_t             side_s7,
	output logic [MAG_W-1:0]  den_s7,
	output logic [HEAD_W-1:0] head_s7 [2],
	output logic [QW-1:0]     tail_s7 [2],
	output logic [1:0]        ovf_s7
);

	logic              valid_s5, valid_s6;
	side_t             side_s5, side_s6;
	logic [MAG_W-1:0]  den_s5, den_s6;
	logic [PP_W-1:0]   pp_lo_s5 [2];
	logic [PP_W-1:0]   pp_hi_s5 [2];
	logic [NUM_W-1:0]  num_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= in_side;
			den_s5  <= in_mag[2];
			for (int l = 0; l < 2; l++) begin
				pp_lo_s5[l] <= PP_W'(in_mag[l][PP_SPLIT-1:0]) * PP_W'(focal);
				pp_hi_s5[l] <= PP_W'(in_mag[l][MAG_W-1:PP_SPLIT]) * PP_W'(focal);
			end
			side_s6 <= side_s5;
			den_s6  <= den_s5;
			for (int l = 0; l < 2; l++) begin
				num_s6[l] <= (NUM_W'(pp_hi_s5[l]) << (PP_SPLIT + OUT_FRAC))
				           + (NUM_W'(pp_lo_s5[l]) << OUT_FRAC);
			end
			side_s7 <= side_s6;
			den_s7  <= den_s6;
			for (int l = 0; l < 2; l++) begin
				// quotient needs more than QW bits exactly when the head reaches the divisor
				ovf_s7[l]  <= num_s6[l][NUM_W-1:QW] >= HEAD_W'(den_s6);
				head_s7[l] <= num_s6[l][NUM_W-1:QW];
				tail_s7[l] <= num_s6[l][QW-1:0];
			end
		end
	end

endmodule

// File: hw/rtl/opc_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// QW stages; depends on opc_pkg.
`timescale 1ns / 1ps
module opc_div import opc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  side_t             in_side,
	input  logic [MAG_W-1:0]  in_den,
	input  logic [HEAD_W-1:0] in_head [2],
	input  logic [QW-1:0]     in_tail [2],
	input  logic [1:0]        in_ovf,
	output logic              out_valid,
	output side_t             out_side,
	output logic [1:0]        out_ovf,
	output logic [QW-1:0]     out_quo [2]
);

	logic             valid_s [QW+1];
	side_t            side_s  [QW+1];
	logic [MAG_W-1:0] den_s   [QW+1];
	logic [1:0]       ovf_s   [QW+1];
	logic [MAG_W-1:0] rem_s   [QW+1][2];
	logic [QW-1:0]    tail_s  [QW+1][2];
	logic [QW-1:0]    quo_s   [QW+1][2];

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;
	assign den_s[0]   = in_den;
	assign ovf_s[0]   = in_ovf;
	for (genvar l = 0; l < 2; l++) begin : g_in
		// head is below the divisor unless the lane overflows, so it fits the remainder
		assign rem_s[0][l]  = in_head[l][MAG_W-1:0];
		assign tail_s[0][l] = in_tail[l];
		assign quo_s[0][l]  = '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [MAG_W:0]   trial [2];
		logic [MAG_W:0]   diff  [2];
		logic             ge    [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem_s[k][l], tail_s[k][l][QW-1]};
				diff[l]  = trial[l] - {1'b0, den_s[k]};
				ge[l]    = trial[l] >= {1'b0, den_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				for (int l = 0; l < 2; l++) begin
					rem_s[k+1][l]  <= ge[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
					tail_s[k+1][l] <= tail_s[k][l] << 1;
					quo_s[k+1][l]  <= {quo_s[k][l][QW-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid  = valid_s[QW];
	assign out_side   = side_s[QW];
	assign out_ovf    = ovf_s[QW];
	assign out_quo[0] = quo_s[QW][0];
	assign out_quo[1] = quo_s[QW][1];

endmodule

// File: tb/sv/object_to_camera_projection_core_checker.sv
// Checker for the projection core: tracks configuration writes, predicts each image result.
// Compares every image transfer with the oldest prediction; depends on opc_pkg.
`timescale 1ns / 1ps
module object_to_camera_projection_core_checker import opc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	input  logic                 point_stall,
	input  point_t               point,
	input  logic                 image_valid,
	input  logic                 image_stall,
	input  image_t               image,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   fail_count,
	output int                   pending
);

	logic [ROT_COL_W-1:0] rot_col [3];
	logic [COORD_W-1:0]   cam [3];
	logic [F_W-1:0]       focal;
	image_t               image_queue [$];

	// -f * num / den with truncation toward zero and saturation; den must be nonzero
	function automatic logic [31:0] scale_ratio(logic signed [63:0] num,
			logic signed [63:0] den, ref logic sat);
		logic [127:0] n_mag;
		logic [127:0] d_mag;
		logic [127:0] q;
		logic         flip;
		flip  = (num < 0) == (den < 0);
		n_mag = 128'(num < 0 ? -num : num);
		d_mag = 128'(den < 0 ? -den : den);
		n_mag = (n_mag * 128'(focal)) << OUT_FRAC;
		q     = n_mag / d_mag;
		if (q == 0)
			return 32'd0;
		if (flip) begin
			if (q > 128'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-q);
		end
		if (q > 128'h7fff_ffff) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		return q[31:0];
	endfunction

	function automatic image_t project_point(point_t p);
		logic signed [63:0] diff [3];
		logic signed [63:0] axis [3];
		logic signed [15:0] r;
		logic               sat;
		image_t             res;
		diff[0] = 64'(p.obj_x) - 64'($signed(cam[0]));
		diff[1] = 64'(p.obj_y) - 64'($signed(cam[1]));
		diff[2] = 64'(p.obj_z) - 64'($signed(cam[2]));
		for (int c = 0; c < 3; c++) begin
			axis[c] = 0;
			for (int k = 0; k < 3; k++) begin
				r = rot_col[c][16*k +: 16];
				axis[c] += 64'(r) * diff[k];
			end
		end
		res.point_out_id = p.point_id;
		sat = 1'b0;
		if (axis[2] == 0) begin
			res.image_x = 0;
			res.image_y = 0;
			res.status  = ST_ZERO_DEPTH;
			return res;
		end
		res.image_x = scale_ratio(axis[0], axis[2], sat);
		res.image_y = scale_ratio(axis[1], axis[2], sat);
		res.status  = sat ? ST_SAT : ST_OK;
		return res;
	endfunction

	assign pending = image_queue.size();

	always @(posedge clk or negedge arst_n) begin
		image_t exp_img;
		if (!arst_n) begin
			rot_col[0] = 48'd16384;
			rot_col[1] = 48'd1073741824;
			rot_col[2] = 48'd70368744177664;
			cam[0] = '0;
			cam[1] = '0;
			cam[2] = '0;
			focal = '0;
			fail_count = 0;
			image_queue.delete();
		end else begin
			if (point_valid && !point_stall)
				image_queue.push_back(project_point(point));
			if (image_valid && !image_stall) begin
				if (image_queue.size() == 0) begin
					$error("image transfer with no prediction waiting: id %h", image.point_out_id);
					fail_count++;
				end else begin
					exp_img = image_queue.pop_front();
					if (image.point_out_id !== exp_img.point_out_id) begin
						$error("point_out_id: expected %h, got %h",
							exp_img.point_out_id, image.point_out_id);
						fail_count++;
					end
					if (image.image_x !== exp_img.image_x) begin
						$error("image_x: expected %0d, got %0d", exp_img.image_x, image.image_x);
						fail_count++;
					end
					if (image.image_y !== exp_img.image_y) begin
						$error("image_y: expected %0d, got %0d", exp_img.image_y, image.image_y);
						fail_count++;
					end
					if (image.status !== exp_img.status) begin
						$error("status: expected %0d, got %0d", exp_img.status, image.status);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ROT_COL_0: rot_col[0] = cfg_data;
					REG_ROT_COL_1: rot_col[1] = cfg_data;
					REG_ROT_COL_2: rot_col[2] = cfg_data;
					REG_CAM_X:     cam[0] = cfg_data[COORD_W-1:0];
					REG_CAM_Y:     cam[1] = cfg_data[COORD_W-1:0];
					REG_CAM_Z:     cam[2] = cfg_data[COORD_W-1:0];
					REG_FOCAL:     focal = cfg_data[F_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: tb/sv/object_to_camera_projection_core_test.sv
// Top of the projection core testbench: clock, reset, configuration phases and point stimulus.
// Instantiates the core and its checker; depends on opc_pkg.
`timescale 1ns / 1ps
module object_to_camera_projection_core_test;
	import opc_pkg::*;

	localparam int PIPE_LAT    = 40;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 point_valid;
	logic                 point_stall;
	point_t               point;
	logic                 image_valid;
	logic                 image_stall;
	image_t               image;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	int                   fail_count;
	int                   pending;
	int                   cycle_count;
	int                   points_sent;
	int                   phases_run;
	logic                 quiet_tail;
	int                   sink_hold;
	logic [31:0]          next_id;
	logic signed [31:0]   cam_now [3];

	object_to_camera_projection_core dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.image_valid(image_valid), .image_stall(image_stall), .image(image),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	object_to_camera_projection_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.image_valid(image_valid), .image_stall(image_stall), .image(image),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: give up long after the slowest correct run would have ended
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("object_to_camera_projection_core_test: FAIL");
			$finish;
		end
	end

	// Sink side: stall in random bursts, none once the tail of the run starts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_stall <= 1'b0;
			sink_hold   <= 0;
		end else if (quiet_tail) begin
			image_stall <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			image_stall <= 1'b1;
			sink_hold   <= $urandom_range(0, 12);
		end else begin
			image_stall <= 1'b0;
			sink_hold   <= $urandom_range(0, 20);
		end
	end

	// Write one register; only called with the pipeline drained
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_CAM_X) cam_now[0] = val[31:0];
		if (idx == REG_CAM_Y) cam_now[1] = val[31:0];
		if (idx == REG_CAM_Z) cam_now[2] = val[31:0];
		@(posedge clk);
	endtask

	// Drop the source, hold until every prediction is matched, then let the pipeline settle
	task automatic drain();
		point_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	// Present one point and hold it until the core takes the transfer
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic allow_gap);
		int gap;
		point_valid <= 1'b1;
		point       <= '{point_id: next_id, obj_x: x, obj_y: y, obj_z: z};
		next_id      = $urandom();
		@(negedge clk);
		while (point_stall) @(negedge clk);
		@(posedge clk);
		points_sent++;
		if (allow_gap && !quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
		return c + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [47:0] rand_rotation();
		logic [47:0] col;
		for (int k = 0; k < 3; k++)
			col[16*k +: 16] = ($urandom_range(0, 9) == 0) ? 16'h8000 : 16'($urandom());
		return col;
	endfunction

	// Mostly points close to the camera so the ratios stay in range, plus raw noise
	task automatic random_points(int count);
		int mode;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 9);
			if (mode < 2)
				send_point($urandom(), $urandom(), $urandom(), 1'b1);
			else if (mode == 2)
				send_point(cam_now[0], cam_now[1], cam_now[2], 1'b1);
			else
				send_point(near(cam_now[0], 4000), near(cam_now[1], 4000),
					near(cam_now[2], 4000), 1'b1);
		end
	endtask

	initial begin
		int f_pick;
		cycle_count  = 0;
		points_sent  = 0;
		phases_run   = 0;
		quiet_tail   = 1'b0;
		point_valid  = 1'b0;
		point        = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		next_id      = 32'hffff_ffff;
		cam_now[0]   = 0;
		cam_now[1]   = 0;
		cam_now[2]   = 0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero focal length gives zero coordinates, depth zero still flagged
		send_point(32'sd100, -32'sd50, 32'sd7, 1'b0);
		send_point(32'sd5, 32'sd5, 32'sd0, 1'b0);
		next_id = 32'h0;
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		drain();

		// Identity rotation, largest focal length: saturation and extremes
		write_reg(REG_FOCAL, 48'hff_ffff);
		send_point(32'sd1, 32'sd1, 32'sd1, 1'b0);
		send_point(-32'sd1, 32'sd1, 32'sd1, 1'b0);
		send_point(32'sh8000_0000, 32'sh8000_0000, -32'sd1, 1'b0);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
		send_point(32'sd0, 32'sd0, 32'sh8000_0000, 1'b0);
		send_point(32'sd3, 32'sd4, 32'sd0, 1'b0);
		drain();
		write_reg(REG_FOCAL, 48'd100);
		send_point(32'sd1000, -32'sd2000, 32'sd4000, 1'b0);
		send_point(-32'sd7, 32'sd9, -32'sd3, 1'b0);
		send_point(32'sd0, 32'sd0, 32'sd1, 1'b0);
		drain();

		// Camera at the coordinate extremes, most negative rotation entries
		write_reg(REG_CAM_X, 48'h8000_0000);
		write_reg(REG_CAM_Y, 48'h7fff_ffff);
		write_reg(REG_CAM_Z, 48'h8000_0000);
		write_reg(REG_ROT_COL_0, 48'h8000_8000_8000);
		write_reg(REG_ROT_COL_1, 48'h7fff_7fff_7fff);
		write_reg(REG_ROT_COL_2, 48'h8000_0000_7fff);
		write_reg(3'd7, 48'hffff_ffff_ffff);
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
		send_point(32'sh8000_0000, 32'sd12345, 32'sh8000_0000, 1'b0);
		drain();

		// Random phases: fresh matrix, camera and focal length each time
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_ROT_COL_0, rand_rotation());
			write_reg(REG_ROT_COL_1, rand_rotation());
			write_reg(REG_ROT_COL_2, (ph == 0) ? 48'h4000_0000_0000 : rand_rotation());
			write_reg(REG_CAM_X, {16'($urandom()), 32'(near(0, 1 << 20))});
			write_reg(REG_CAM_Y, 48'($signed(near(0, 1 << 20))));
			write_reg(REG_CAM_Z, (ph == 5) ? 48'($urandom()) : 48'($signed(near(0, 1 << 20))));
			f_pick = $urandom_range(0, 3);
			write_reg(REG_FOCAL, {24'($urandom()),
				f_pick == 0 ? 24'hff_ffff : 24'($urandom_range(1, 5000))});
			if (ph == 5)
				quiet_tail = 1'b1;
			random_points(55);
			// Hold the source until everything in flight has landed
			if (ph == 2) begin
				point_valid <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			random_points(50);
			drain();
			phases_run++;
		end

		point_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);

		$display("Projected %0d points over %0d random configurations plus directed", points_sent,
			phases_run);
		$display("cases: reset settings, zero depth, saturation and extreme coordinates.");
		if (fail_count == 0)
			$display("object_to_camera_projection_core_test: PASS");
		else
			$display("object_to_camera_projection_core_test: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/opc_pkg.sv
hw/rtl/opc_front.sv
hw/rtl/opc_scale.sv
hw/rtl/opc_div.sv
hw/rtl/object_to_camera_projection_core.sv
tb/sv/object_to_camera_projection_core_checker.sv
tb/sv/object_to_camera_projection_core_test.sv
